### hw/rtl/ssbm_pkg.sv
// Package for the sparse symmetric bit matrix core.
// Holds request/result structs and sizing constants; no dependencies.
package ssbm_pkg;
	localparam int NODE_COUNT_DEF = 1024;
	localparam int MAX_ROWS_DEF = 32;
	localparam int IDX_W = 10;
	localparam int OFF_W = 7;
	localparam int MASK_W = 8;
	localparam int ENTRY_W = OFF_W + MASK_W;
	localparam logic CMD_SET = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef struct packed {
		logic command;
		logic [IDX_W-1:0] patch_a;
		logic [IDX_W-1:0] patch_b;
	} req_t;

	typedef struct packed {
		logic visible;
		logic status;
	} rsp_t;
endpackage

### hw/rtl/sparse_symmetric_bit_matrix_core.sv
// Sparse symmetric bit matrix core: count and entry memories with a sequencer; uses ssbm_pkg.
// Equal or out-of-range indices go straight to the result; otherwise a count read, then
// search probes (at most log2(MAX_ROWS)+1) of address, read wait and compare, then a miss,
// an OR write, or a read, wait and write per entry moved plus an insert. One request at a time;
// the next is taken the cycle after the result leaves.
// After reset a clearing pass over every column zeroes the counts before in_ready rises.
module sparse_symmetric_bit_matrix_core #(
	parameter int NODE_COUNT = ssbm_pkg::NODE_COUNT_DEF,
	parameter int MAX_ROWS = ssbm_pkg::MAX_ROWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ssbm_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ssbm_pkg::rsp_t out_data
);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int PW = $clog2(NODE_COUNT);
	localparam int SW = $clog2(NODE_COUNT) + 1;
	localparam int AW = (NODE_COUNT * MAX_ROWS > 1) ? $clog2(NODE_COUNT * MAX_ROWS) : 1;
	localparam int HW = CW + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SRCH = 4'd1;
	localparam logic [3:0] ST_RDW = 4'd2;
	localparam logic [3:0] ST_CMP = 4'd3;
	localparam logic [3:0] ST_OR = 4'd4;
	localparam logic [3:0] ST_MVRD = 4'd5;
	localparam logic [3:0] ST_MVW8 = 4'd6;
	localparam logic [3:0] ST_MVWR = 4'd7;
	localparam logic [3:0] ST_INS = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;
	localparam logic [3:0] ST_CLR = 4'd10;
	localparam logic [3:0] ST_CNT = 4'd11;

	logic [3:0] state_q;
	logic cmd_q;
	logic [PW-1:0] col_q;
	logic [ssbm_pkg::OFF_W-1:0] off_q;
	logic [2:0] bit_q;
	logic signed [HW-1:0] lo_q, hi_q, mid_q;
	logic [CW-1:0] cnt_q, mv_q;
	logic [ssbm_pkg::ENTRY_W-1:0] mem [NODE_COUNT*MAX_ROWS];
	logic [ssbm_pkg::ENTRY_W-1:0] rd_q, hold_q;
	logic [CW-1:0] count_mem [NODE_COUNT];
	logic [CW-1:0] cnt_rd_q;
	logic [PW-1:0] clr_q;
	ssbm_pkg::rsp_t rsp_q;

	localparam int IDX_W_LOCAL = ssbm_pkg::IDX_W;
	logic [IDX_W_LOCAL-1:0] a_w, b_w, lo_i, hi_i;
	logic [AW-1:0] addr;
	logic we;
	logic [ssbm_pkg::ENTRY_W-1:0] wdata;
	logic [PW-1:0] cnt_addr;
	logic cnt_we;
	logic [CW-1:0] cnt_wdata;
	logic [ssbm_pkg::OFF_W-1:0] eoff;
	logic signed [HW-1:0] mid_c;

	assign a_w = in_data.patch_a;
	assign b_w = in_data.patch_b;
	assign lo_i = (a_w < b_w) ? a_w : b_w;
	assign hi_i = (a_w < b_w) ? b_w : a_w;
	assign eoff = rd_q[ssbm_pkg::ENTRY_W-1:ssbm_pkg::MASK_W];
	assign mid_c = lo_q + ((hi_q - lo_q) >>> 1);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign out_data = rsp_q;

	// Single memory port: address and write enable by state.
	always_comb begin
		addr = AW'(col_q * MAX_ROWS);
		we = 1'b0;
		wdata = rd_q;
		unique case (state_q)
			ST_SRCH, ST_RDW, ST_CMP: addr = AW'(col_q * MAX_ROWS + RW'(mid_q));
			ST_OR: begin
				addr = AW'(col_q * MAX_ROWS + RW'(mid_q));
				we = 1'b1;
				wdata = rd_q | ssbm_pkg::ENTRY_W'(1 << bit_q);
			end
			ST_MVRD, ST_MVW8: addr = AW'(col_q * MAX_ROWS + RW'(mv_q - 1'b1));
			ST_MVWR: begin
				addr = AW'(col_q * MAX_ROWS + RW'(mv_q));
				we = 1'b1;
				wdata = hold_q;
			end
			ST_INS: begin
				addr = AW'(col_q * MAX_ROWS + RW'(mv_q));
				we = 1'b1;
				wdata = {off_q, ssbm_pkg::MASK_W'(1 << bit_q)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	// Column counts live in their own single-port memory. The clearing pass
	// walks every column after reset; the idle state reads the count of the
	// column named by the waiting request so it is ready in the next cycle.
	always_comb begin
		cnt_addr = col_q;
		cnt_we = 1'b0;
		cnt_wdata = cnt_q + 1'b1;
		unique case (state_q)
			ST_CLR: begin
				cnt_addr = clr_q;
				cnt_we = 1'b1;
				cnt_wdata = '0;
			end
			ST_IDLE: cnt_addr = PW'(lo_i);
			ST_INS: cnt_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			count_mem[cnt_addr] <= cnt_wdata;
		cnt_rd_q <= count_mem[cnt_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PW'(NODE_COUNT - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_data.command;
						col_q <= PW'(lo_i);
						off_q <= hi_i[ssbm_pkg::IDX_W-1:3];
						bit_q <= hi_i[2:0];
						if (a_w == b_w) begin
							// Equal indices are always visible to a test; a set is ignored.
							rsp_q <= '{visible: (in_data.command == ssbm_pkg::CMD_TEST),
								status: 1'b0};
							state_q <= ST_DONE;
						end else if (SW'(hi_i) >= SW'(NODE_COUNT)) begin
							rsp_q <= '0;
							state_q <= ST_DONE;
						end else begin
							rsp_q <= '0;
							state_q <= ST_CNT;
						end
					end
				end
				ST_CNT: begin
					// The count read started at acceptance is now registered.
					cnt_q <= cnt_rd_q;
					lo_q <= '0;
					hi_q <= HW'(cnt_rd_q) - HW'(1);
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					if (lo_q <= hi_q) begin
						mid_q <= mid_c;
						state_q <= ST_RDW;
					end else if (cmd_q == ssbm_pkg::CMD_TEST) begin
						state_q <= ST_DONE;
					end else if (CW'(cnt_q) >= CW'(MAX_ROWS)) begin
						rsp_q.status <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						// lo is the insertion point; move the entries at and above it up by one.
						mv_q <= cnt_q;
						state_q <= (cnt_q > CW'(lo_q)) ? ST_MVRD : ST_INS;
					end
				end
				ST_RDW: state_q <= ST_CMP;
				ST_CMP: begin
					if (eoff < off_q) begin
						lo_q <= mid_q + HW'(1);
						state_q <= ST_SRCH;
					end else if (eoff > off_q) begin
						hi_q <= mid_q - HW'(1);
						state_q <= ST_SRCH;
					end else if (cmd_q == ssbm_pkg::CMD_TEST) begin
						rsp_q.visible <= rd_q[bit_q];
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_OR;
					end
				end
				ST_OR: state_q <= ST_DONE;
				ST_MVRD: state_q <= ST_MVW8;
				ST_MVW8: begin
					hold_q <= rd_q;
					state_q <= ST_MVWR;
				end
				ST_MVWR: begin
					mv_q <= mv_q - 1'b1;
					state_q <= ((mv_q - 1'b1) > CW'(lo_q)) ? ST_MVRD : ST_INS;
				end
				ST_INS: state_q <= ST_DONE;
				ST_DONE: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sim/testbench.sv
// Self-checking testbench for sparse_symmetric_bit_matrix_core.
// Depends on ssbm_pkg and the core RTL; drives requests and checks results
// against an in-bench model of the sorted per-column bit lists.
`timescale 1ns / 100ps

module testbench;
	localparam int NP = ssbm_pkg::NODE_COUNT_DEF;
	localparam int MR = ssbm_pkg::MAX_ROWS_DEF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ssbm_pkg::req_t in_data;
	logic out_valid;
	logic out_ready;
	ssbm_pkg::rsp_t out_data;

	sparse_symmetric_bit_matrix_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Model state: per column, a sorted list of byte offsets and their masks.
	logic [ssbm_pkg::OFF_W-1:0] col_off [NP][MR];
	logic [ssbm_pkg::MASK_W-1:0] col_mask [NP][MR];
	int unsigned col_len [NP] = '{default: 0};

	ssbm_pkg::req_t pending_reqs[$];
	ssbm_pkg::rsp_t expected_rsps[$];
	int errors = 0;
	int num_sets = 0, num_tests = 0, num_full = 0, num_hits = 0;
	int send_idle_pct = 31;
	int recv_idle_pct = 64;
	bit hold_go = 0;
	bit recv_hold;
	bit send_pause = 0;

	// Apply one request to the model and return its expected result.
	function automatic ssbm_pkg::rsp_t apply_visibility(ssbm_pkg::req_t r);
		ssbm_pkg::rsp_t res;
		int lo_idx, hi_idx, off, pos, ins;
		logic [ssbm_pkg::MASK_W-1:0] bitm;
		res = '0;
		if (r.patch_a == r.patch_b) begin
			res.visible = (r.command == ssbm_pkg::CMD_TEST);
			return res;
		end
		lo_idx = int'((r.patch_a < r.patch_b) ? r.patch_a : r.patch_b);
		hi_idx = int'((r.patch_a < r.patch_b) ? r.patch_b : r.patch_a);
		if (hi_idx >= NP)
			return res;
		off = hi_idx >> 3;
		bitm = 8'(1) << (hi_idx & 7);
		pos = -1;
		for (int i = 0; i < col_len[lo_idx]; i++)
			if (col_off[lo_idx][i] == off)
				pos = i;
		if (r.command == ssbm_pkg::CMD_TEST) begin
			res.visible = (pos >= 0) && ((col_mask[lo_idx][pos] & bitm) != 0);
			return res;
		end
		if (pos >= 0) begin
			col_mask[lo_idx][pos] |= bitm;
			return res;
		end
		if (col_len[lo_idx] >= MR) begin
			res.status = 1'b1;
			return res;
		end
		ins = 0;
		while (ins < col_len[lo_idx] && col_off[lo_idx][ins] < off)
			ins++;
		for (int i = col_len[lo_idx]; i > ins; i--) begin
			col_off[lo_idx][i] = col_off[lo_idx][i-1];
			col_mask[lo_idx][i] = col_mask[lo_idx][i-1];
		end
		col_off[lo_idx][ins] = off[ssbm_pkg::OFF_W-1:0];
		col_mask[lo_idx][ins] = bitm;
		col_len[lo_idx]++;
		return res;
	endfunction

	function automatic ssbm_pkg::req_t mk_req(logic cmd, int a, int b);
		ssbm_pkg::req_t r;
		r.command = cmd;
		r.patch_a = a[ssbm_pkg::IDX_W-1:0];
		r.patch_b = b[ssbm_pkg::IDX_W-1:0];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: presents the head of the request queue; the model is updated
	// at the accepting edge, so expectations stay in acceptance order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_rsps.push_back(apply_visibility(in_data));
				if (in_data.command == ssbm_pkg::CMD_TEST) num_tests++; else num_sets++;
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && !send_pause &&
						$urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_reqs.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receive hold-off, counted here so the monitor only sees a flag.
	initial begin
		recv_hold = 1'b0;
		wait (hold_go);
		recv_hold <= 1'b1;
		repeat (300) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// Monitor: checks each result against the oldest expectation and
	// randomly stalls the result channel, with an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result visible=%0b status=%0b",
						$time, out_data.visible, out_data.status);
					errors++;
				end else begin
					ssbm_pkg::rsp_t e;
					e = expected_rsps.pop_front();
					if (e.visible != out_data.visible) begin
						$display("%0t: visible mismatch expected %0b actual %0b",
							$time, e.visible, out_data.visible);
						errors++;
					end
					if (e.status != out_data.status) begin
						$display("%0t: status mismatch expected %0b actual %0b",
							$time, e.status, out_data.status);
						errors++;
					end
					if (e.status) num_full++;
					if (e.visible) num_hits++;
				end
			end
			if (recv_hold)
				out_ready <= 1'b0;
			else
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int col, base;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: equal indices, index extremes, a set then a test
		// in both orders, and a miss on the same byte.
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 5, 5));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 5, 5));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 1023, 1023));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 0, 1023));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 1023, 0));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 0, 1023));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 1023, 0));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 0, 1022));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 0, 1));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 0, 1016));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 512, 1022));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 1022, 512));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 0, 1));

		// Fill column 7 to capacity with offsets in descending order so that
		// every insert after the first shifts, then hit the full case and OR into a full column.
		for (int i = 31; i >= 0; i--)
			pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 7, 8 + i * 8 + (i & 7)));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 7, 1016));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_SET, 8 + 5 * 8 + 1, 7));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 7, 8 + 5 * 8 + 1));
		pending_reqs.push_back(mk_req(ssbm_pkg::CMD_TEST, 7, 1016));
		wait_drained();

		// Random part in three idling phases; a few hot columns get deep lists.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 64 : 0;
			recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 31 : 0;
			if (phase == 1) hold_go = 1'b1;
			for (int n = 0; n < 168; n++) begin
				int a, b;
				if ($urandom_range(3) != 0) begin
					col = $urandom_range(3) * 255;
					base = $urandom_range(NP - 1);
					a = col;
					b = base;
				end else begin
					a = $urandom_range(NP - 1);
					b = ($urandom_range(9) == 0) ? a : $urandom_range(NP - 1);
				end
				if ($urandom_range(1)) begin
					int t;
					t = a; a = b; b = t;
				end
				pending_reqs.push_back(mk_req(1'($urandom_range(1)), a, b));
			end
			// Halfway through, the sender pauses until every expected result is back.
			while (pending_reqs.size() > 84) @(posedge clk);
			send_pause = 1'b1;
			while (in_valid || expected_rsps.size() > 0) @(posedge clk);
			send_pause = 1'b0;
			wait_drained();
		end
		repeat (100) @(posedge clk);

		$display("Covered %0d sets and %0d tests (%0d hits, %0d full-column drops)",
			num_sets, num_tests, num_hits, num_full);
		$display("under three idle mixes, a long receive hold-off and a sender pause.");
		if (errors == 0 && expected_rsps.size() == 0)
			$display("sparse_symmetric_bit_matrix_core test passed");
		else
			$display("sparse_symmetric_bit_matrix_core test failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("sparse_symmetric_bit_matrix_core test failed");
		$finish;
	end

endmodule
